### sv/mic_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mic_pkg: shared constants and helpers for the cofactor matrix inverter
// Matrix geometry, store sizes and the Q16.16 saturation helper.
// ----------------------------------------------------------------------------
package mic_pkg;

  // The sequencer expands 3x3 minors directly, so the size is fixed at four.
  localparam int MATRIX_SIZE = 4;
  localparam int CELLS       = MATRIX_SIZE * MATRIX_SIZE;
  localparam int ROW_W       = $clog2(MATRIX_SIZE);
  localparam int ADDR_W      = 2 * ROW_W;
  localparam int LOAD_W      = $clog2(CELLS + 1);
  localparam int DATA_W      = 32;

  typedef logic [ROW_W-1:0]  row_t;
  typedef logic [ADDR_W-1:0] addr_t;

  // Clamp a 64-bit signed value to the signed 32-bit range.
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] res;
    if (v > 64'sd2147483647) begin
      res = 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      res = 32'sh80000000;
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

  // Map an index of a minor back to the full matrix, skipping the removed one.
  function automatic row_t skip_idx(input row_t i, input row_t removed);
    row_t res;
    res = (i >= removed) ? row_t'(i + row_t'(1)) : i;
    return res;
  endfunction

endpackage

### sv/mic_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mic_ram: generic simple dual-port RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module mic_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Registered read; reading the entry being written returns its old contents.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/matrix_inverse_cofactor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_inverse_cofactor: 4x4 Q16.16 matrix inverse by adjugate
// Loads a matrix item by item, expands all cofactors and the determinant,
// then streams out the inverse in row-major order.
// ----------------------------------------------------------------------------
// Usage. An input item (one matrix element, row-major) is taken on a rising
// edge with start high and busy low; loading accepts one item per cycle and
// busy stays low. Elements past the sixteenth are dropped. The item marked
// last raises busy and starts the computation.
// Computation runs every product through one shared multiplier fed from the
// single read port of the matrix RAM: each product reads one operand, reads
// the other, captures it, multiplies and accumulates before the next starts;
// nine products and one cofactor write per minor, plus four products for the
// determinant. Each inverse element then takes a cofactor RAM read and a
// 48-step restoring divider (skipped when the matrix is singular), and the
// next element starts only after the previous one is emitted.
// Each result is shown for one cycle with out_valid high; the receiver
// cannot stall and must take it then. out_result_last marks the sixteenth.
// Reset clears the load position and the sequencer; the RAM contents are
// not cleared and there is no clearing pass.
// ----------------------------------------------------------------------------
module matrix_inverse_cofactor (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic signed [31:0]  in_element_value,
  input  logic                in_element_last,
  output logic                out_valid,
  output logic signed [31:0]  out_inverse_value,
  output logic                out_singular,
  output logic                out_result_last
);
  import mic_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_RDA, S_RDB, S_CAPB, S_MUL, S_ACC, S_WCOF,
    S_ORD, S_OWAIT, S_DIV, S_EMIT
  } state_t;

  state_t              state_r;
  logic [LOAD_W-1:0]   load_idx_r;
  row_t                r_r, c_r, k_r;
  logic [1:0]          j_r;
  logic signed [31:0]  opa_r, opb_r, d2_r, d3_r, det_r, q0_r;
  logic signed [63:0]  prod_r, acc3_r, acc4_r;
  logic                sing_r, neg_r;
  logic [ADDR_W-1:0]   oi_r;
  logic [31:0]         den_r, rem_r;
  logic [47:0]         quo_r;
  logic [5:0]          cnt_r;

  // RAM ports
  logic                mat_we, cof_we;
  addr_t               mat_raddr, cof_raddr, cof_waddr;
  logic [31:0]         mat_rdata, cof_rdata, cof_wdata;

  mic_ram #(.WIDTH(DATA_W), .DEPTH(CELLS)) u_mat_ram (
    .clk, .we(mat_we), .waddr(load_idx_r[ADDR_W-1:0]), .wdata(in_element_value),
    .raddr(mat_raddr), .rdata(mat_rdata)
  );

  mic_ram #(.WIDTH(DATA_W), .DEPTH(CELLS)) u_cof_ram (
    .clk, .we(cof_we), .waddr(cof_waddr), .wdata(cof_wdata),
    .raddr(cof_raddr), .rdata(cof_rdata)
  );

  assign busy = (state_r != S_IDLE);

  // Operand addresses for the current minor, term and operation.
  row_t ca, cb, row0, row1, row2, col_a, col_b, col_k;
  addr_t addr_a, addr_b;
  always_comb begin
    ca    = (k_r == row_t'(0)) ? row_t'(1) : row_t'(0);
    cb    = (k_r == row_t'(2)) ? row_t'(1) : row_t'(2);
    row0  = skip_idx(row_t'(0), r_r);
    row1  = skip_idx(row_t'(1), r_r);
    row2  = skip_idx(row_t'(2), r_r);
    col_a = skip_idx(ca, c_r);
    col_b = skip_idx(cb, c_r);
    col_k = skip_idx(k_r, c_r);
    case (j_r)
      2'd0: begin
        addr_a = {row1, col_a};
        addr_b = {row2, col_b};
      end
      2'd1: begin
        addr_a = {row1, col_b};
        addr_b = {row2, col_a};
      end
      2'd2: begin
        addr_a = {row0, col_k};
        addr_b = {row0, col_k};
      end
      default: begin
        addr_a = {row_t'(0), c_r};
        addr_b = {row_t'(0), c_r};
      end
    endcase
  end

  assign mat_we    = (state_r == S_IDLE) && start && (load_idx_r < LOAD_W'(CELLS));
  assign mat_raddr = (state_r == S_RDB) ? addr_b : addr_a;

  // Truncated Q16.16 product and the cofactor to store.
  logic signed [31:0] q_w, d3_w, cof_w;
  assign q_w   = sat32(prod_r / 64'sd65536);
  assign d3_w  = sat32(acc3_r);
  assign cof_w = (r_r[0] ^ c_r[0]) ? sat32(-64'(d3_w)) : d3_w;

  assign cof_we    = (state_r == S_WCOF);
  assign cof_waddr = {r_r, c_r};
  assign cof_wdata = cof_w;
  // Inverse (i,j) reads cofactor (j,i).
  assign cof_raddr = {oi_r[ROW_W-1:0], oi_r[ADDR_W-1:ROW_W]};

  // Divider step and signed quotient.
  logic [32:0]        rem_t;
  logic               ge_w;
  logic signed [63:0] quo64;
  logic signed [31:0] res_w;
  logic [31:0]        cof_mag, det_mag;
  always_comb begin
    rem_t   = {rem_r, quo_r[47]};
    ge_w    = (rem_t >= {1'b0, den_r});
    quo64   = $signed({16'd0, quo_r});
    res_w   = sat32(neg_r ? -quo64 : quo64);
    cof_mag = cof_rdata[31] ? (~cof_rdata + 32'd1) : cof_rdata;
    det_mag = det_r[31] ? (~det_r + 32'd1) : det_r;
  end

  // Sequencer, datapath registers and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      load_idx_r <= '0;
      out_valid  <= 1'b0;
    end else begin
      out_valid <= (state_r == S_EMIT);
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            if (in_element_last) begin
              load_idx_r <= '0;
              r_r        <= '0;
              c_r        <= '0;
              k_r        <= '0;
              j_r        <= '0;
              acc3_r     <= '0;
              acc4_r     <= '0;
              state_r    <= S_RDA;
            end else if (load_idx_r < LOAD_W'(CELLS)) begin
              load_idx_r <= load_idx_r + LOAD_W'(1);
            end
          end
        end
        S_RDA: state_r <= S_RDB;
        S_RDB: begin
          opa_r   <= mat_rdata;
          state_r <= S_CAPB;
        end
        S_CAPB: begin
          case (j_r) inside
            2'd0, 2'd1: opb_r <= mat_rdata;
            2'd2:       opb_r <= d2_r;
            default:    opb_r <= d3_r;
          endcase
          state_r <= S_MUL;
        end
        S_MUL: begin
          prod_r  <= opa_r * opb_r;
          state_r <= S_ACC;
        end
        S_ACC: begin
          case (j_r)
            2'd0: begin
              q0_r    <= q_w;
              j_r     <= 2'd1;
              state_r <= S_RDA;
            end
            2'd1: begin
              d2_r    <= sat32(64'(q0_r) - 64'(q_w));
              j_r     <= 2'd2;
              state_r <= S_RDA;
            end
            2'd2: begin
              acc3_r <= k_r[0] ? acc3_r - 64'(q_w) : acc3_r + 64'(q_w);
              j_r    <= 2'd0;
              if (k_r == row_t'(2)) begin
                state_r <= S_WCOF;
              end else begin
                k_r     <= k_r + row_t'(1);
                state_r <= S_RDA;
              end
            end
            default: begin
              // Determinant term along the first row; then next minor.
              acc4_r  <= c_r[0] ? acc4_r - 64'(q_w) : acc4_r + 64'(q_w);
              j_r     <= 2'd0;
              state_r <= S_RDA;
              // Finishing the last minor of the first row moves on to the next row.
              if (c_r == row_t'(MATRIX_SIZE - 1)) begin
                r_r <= r_r + row_t'(1);
                c_r <= '0;
              end else begin
                c_r <= c_r + row_t'(1);
              end
            end
          endcase
        end
        S_WCOF: begin
          d3_r   <= d3_w;
          acc3_r <= '0;
          k_r    <= '0;
          if (r_r == row_t'(0)) begin
            j_r     <= 2'd3;
            state_r <= S_RDA;
          end else if (c_r == row_t'(MATRIX_SIZE - 1)) begin
            if (r_r == row_t'(MATRIX_SIZE - 1)) begin
              det_r   <= sat32(acc4_r);
              sing_r  <= (sat32(acc4_r) == 32'sd0);
              oi_r    <= '0;
              state_r <= S_ORD;
            end else begin
              r_r     <= r_r + row_t'(1);
              c_r     <= '0;
              state_r <= S_RDA;
            end
          end else begin
            c_r     <= c_r + row_t'(1);
            state_r <= S_RDA;
          end
        end
        S_ORD: state_r <= S_OWAIT;
        S_OWAIT: begin
          neg_r   <= cof_rdata[31] ^ det_r[31];
          den_r   <= det_mag;
          quo_r   <= {cof_mag, 16'd0};
          rem_r   <= '0;
          cnt_r   <= '0;
          state_r <= sing_r ? S_EMIT : S_DIV;
        end
        S_DIV: begin
          rem_r <= ge_w ? 32'(rem_t - {1'b0, den_r}) : rem_t[31:0];
          quo_r <= {quo_r[46:0], ge_w};
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == 6'd47) begin
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          out_inverse_value <= sing_r ? 32'sd0 : res_w;
          out_singular      <= sing_r;
          out_result_last   <= (oi_r == ADDR_W'(CELLS - 1));
          if (oi_r == ADDR_W'(CELLS - 1)) begin
            state_r <= S_IDLE;
          end else begin
            oi_r    <= oi_r + ADDR_W'(1);
            state_r <= S_ORD;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // A result only follows a cycle of computation.
  a_out_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe without preceding computation");

  // A singular matrix yields zero values.
  a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_singular) |-> (out_inverse_value == 32'sd0))
    else $error("singular result carries a nonzero value");

  // A plain load item causes no result.
  a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !in_element_last) |=> !out_valid)
    else $error("result strobe after a load item");

  // The load position never passes the store size.
  a_load_bound: assert property (@(posedge clk) disable iff (!rst_n)
    load_idx_r <= LOAD_W'(CELLS))
    else $error("load position out of range");

endmodule
